[design/acet_pkg.sv]
package acet_pkg;

    localparam int CharWidth     = 8;
    localparam int IndexWidth    = 16;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;
    localparam int NumTally      = 12;

    localparam logic [CharWidth-1:0]  GapChar   = 8'd45;
    localparam logic [CharWidth-1:0]  MatchChar = 8'd124;
    localparam logic [IndexWidth-1:0] IndexMax  = {IndexWidth{1'b1}};

    // tally slots, in result order
    localparam int TALLY_ERR     = 0;
    localparam int TALLY_HOMO    = 1;
    localparam int TALLY_MM      = 2;
    localparam int TALLY_INDEL   = 3;
    localparam int TALLY_DIFF    = 4;
    localparam int TALLY_MATCH   = 5;
    localparam int TALLY_REFLEN  = 6;
    localparam int TALLY_READLEN = 7;
    localparam int TALLY_RHOMO   = 8;
    localparam int TALLY_RMM     = 9;
    localparam int TALLY_RINS    = 10;
    localparam int TALLY_RDEL    = 11;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_SLOP         = 2'd0,
        CFG_REGION_EN    = 2'd1,
        CFG_REGION_START = 2'd2,
        CFG_REGION_STOP  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [IndexWidth-1:0] slop;
        logic                  region_en;
        logic [IndexWidth-1:0] region_start;
        logic [IndexWidth-1:0] region_stop;
    } t_cfg;

    typedef logic [NumTally-1:0] t_hits;

endpackage

[design/alignment_column_error_tally_core.sv]
// Alignment column error tally. Feed one padded alignment column per word
// (reference, read and match characters, tlast on the final column); one word
// of twelve saturating counters comes out per alignment, on the final column.
// A column is accepted every cycle, except that a final column waits in the
// input register while the previous result word is still unread. The input
// register holds each column; the classifiers for the held and final columns
// and the counter adders then form one combinational pass into the result
// register, which the final column loads once it leaves the input register.
// Counters saturate at 2**COUNT_WIDTH - 1; column indexes stop at 65535. Write
// the configuration registers only between alignments.
module alignment_column_error_tally_core
    import acet_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    localparam int OutBits = ((NumTally * COUNT_WIDTH + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [23:0]              i_s_tdata,  // ref_char, read_char, match_char
    input  logic                     i_s_tlast,  // last_column
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // error, homopolymer, mismatch, indel, total_diff, match, reference_length,
    // read_length, region_homopolymer, region_mismatch, region_insertion,
    // region_deletion counts, zero padded
    output logic [OutBits-1:0]       o_m_tdata,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_data
);

    t_cfg r_cfg;

    logic                  r_in_valid, r_in_last;
    logic [CharWidth-1:0]  r_in_ref, r_in_read, r_in_match;

    logic                  r_held_valid, r_prev_valid;
    logic [CharWidth-1:0]  r_held_ref, r_held_read, r_held_match;
    logic [CharWidth-1:0]  r_prev_ref, r_prev_read;
    logic [IndexWidth-1:0] r_col_index, n_col_index;

    logic                  r_out_valid;
    logic [OutBits-1:0]    r_out_data, n_out_data;

    logic                  advance;
    t_hits                 hits_a, hits_b;
    logic [COUNT_WIDTH-1:0] tally_next [NumTally];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SLOP:         r_cfg.slop         <= i_cfg_data;
                CFG_REGION_EN:    r_cfg.region_en    <= i_cfg_data[0];
                CFG_REGION_START: r_cfg.region_start <= i_cfg_data;
                CFG_REGION_STOP:  r_cfg.region_stop  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stall only a final column whose result would overwrite a pending word
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ref   <= i_s_tdata[7:0];
            r_in_read  <= i_s_tdata[15:8];
            r_in_match <= i_s_tdata[23:16];
            r_in_last  <= i_s_tlast;
        end
    end

    // held column, now that its right neighbour is known
    acet_classify u_class_held (
        .i_en        (r_held_valid),
        .i_cfg       (r_cfg),
        .i_ref       (r_held_ref),
        .i_read      (r_held_read),
        .i_match     (r_held_match),
        .i_index     (r_col_index),
        .i_has_prev  (r_prev_valid),
        .i_prev_ref  (r_prev_ref),
        .i_prev_read (r_prev_read),
        .i_has_next  (1'b1),
        .i_next_ref  (r_in_ref),
        .i_next_read (r_in_read),
        .o_hits      (hits_a)
    );

    always_comb begin
        n_col_index = r_col_index;
        if (r_held_valid && r_col_index != IndexMax) begin
            n_col_index = r_col_index + 1'b1;
        end
    end

    // final column, no right neighbour
    acet_classify u_class_last (
        .i_en        (r_in_last),
        .i_cfg       (r_cfg),
        .i_ref       (r_in_ref),
        .i_read      (r_in_read),
        .i_match     (r_in_match),
        .i_index     (n_col_index),
        .i_has_prev  (r_held_valid),
        .i_prev_ref  (r_held_ref),
        .i_prev_read (r_held_read),
        .i_has_next  (1'b0),
        .i_next_ref  (r_in_ref),
        .i_next_read (r_in_read),
        .o_hits      (hits_b)
    );

    acet_tally #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tally (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (advance),
        .i_clear  (r_in_last),
        .i_hits_a (hits_a),
        .i_hits_b (hits_b),
        .o_next   (tally_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_prev_valid <= 1'b0;
            r_col_index  <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_held_valid <= 1'b0;
                r_prev_valid <= 1'b0;
                r_col_index  <= '0;
            end else begin
                r_held_valid <= 1'b1;
                r_prev_valid <= r_held_valid;
                r_col_index  <= n_col_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_prev_ref   <= r_held_ref;
            r_prev_read  <= r_held_read;
            r_held_ref   <= r_in_ref;
            r_held_read  <= r_in_read;
            r_held_match <= r_in_match;
        end
    end

    always_comb begin
        n_out_data = '0;
        for (int k = 0; k < NumTally; k++) begin
            n_out_data[k*COUNT_WIDTH +: COUNT_WIDTH] = tally_next[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_prev_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev_valid |-> r_held_valid)
        else $error("prev column valid without a held column");

    a_index_needs_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_index != '0) |-> r_prev_valid)
        else $error("column index advanced without a previous column");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (!r_held_valid && r_col_index == '0 && r_out_valid))
        else $error("final column did not clear state and post a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready && r_in_valid && r_in_last) |-> !advance)
        else $error("pending result would be overwritten");

endmodule

[design/acet_classify.sv]
module acet_classify
    import acet_pkg::*;
(
    input  logic                  i_en,
    input  t_cfg                  i_cfg,
    input  logic [CharWidth-1:0]  i_ref,
    input  logic [CharWidth-1:0]  i_read,
    input  logic [CharWidth-1:0]  i_match,
    input  logic [IndexWidth-1:0] i_index,
    input  logic                  i_has_prev,
    input  logic [CharWidth-1:0]  i_prev_ref,
    input  logic [CharWidth-1:0]  i_prev_read,
    input  logic                  i_has_next,
    input  logic [CharWidth-1:0]  i_next_ref,
    input  logic [CharWidth-1:0]  i_next_read,
    output t_hits                 o_hits
);

    logic rgap, qgap, is_match, ref_side, read_side, in_slop, in_region;

    always_comb begin
        rgap      = (i_ref == GapChar);
        qgap      = (i_read == GapChar);
        is_match  = (i_match == MatchChar);
        ref_side  = (i_has_prev && i_prev_ref == i_ref) || (i_has_next && i_next_ref == i_ref);
        read_side = (i_has_prev && i_prev_read == i_read)
                    || (i_has_next && i_next_read == i_read);
        in_slop   = (i_index >= i_cfg.slop);
        in_region = i_cfg.region_en && (i_index >= i_cfg.region_start)
                    && (i_index <= i_cfg.region_stop);

        o_hits = '0;
        if (i_en) begin
            o_hits[TALLY_REFLEN]  = !rgap;
            o_hits[TALLY_READLEN] = !qgap;
            o_hits[TALLY_MATCH]   = is_match;
            o_hits[TALLY_DIFF]    = !is_match;
            if (!is_match && in_slop) begin
                o_hits[TALLY_ERR]   = 1'b1;
                o_hits[TALLY_HOMO]  = (!rgap && ref_side) || (!qgap && read_side);
                o_hits[TALLY_MM]    = !rgap && !qgap;
                o_hits[TALLY_INDEL] = rgap || qgap;
            end
            // region homopolymer test looks at the strand opposite the gap
            if (!is_match && in_region) begin
                o_hits[TALLY_RHOMO] = (rgap && read_side) || (qgap && ref_side);
                o_hits[TALLY_RMM]   = !rgap && !qgap;
                o_hits[TALLY_RINS]  = rgap && !qgap;
                o_hits[TALLY_RDEL]  = !rgap && qgap;
            end
        end
    end

endmodule

[design/acet_tally.sv]
module acet_tally
    import acet_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_clear,
    input  t_hits                  i_hits_a,
    input  t_hits                  i_hits_b,
    output logic [COUNT_WIDTH-1:0] o_next [NumTally]
);

    logic [COUNT_WIDTH-1:0] r_cnt [NumTally];
    logic [COUNT_WIDTH:0]   sum   [NumTally];

    always_comb begin
        for (int k = 0; k < NumTally; k++) begin
            sum[k] = {1'b0, r_cnt[k]} + {{COUNT_WIDTH{1'b0}}, i_hits_a[k]}
                     + {{COUNT_WIDTH{1'b0}}, i_hits_b[k]};
            // at most two steps past the top, so the carry bit flags overflow
            o_next[k] = sum[k][COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[k][COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NumTally; k++) begin
            if (!i_rst_n) begin
                r_cnt[k] <= '0;
            end else if (i_adv) begin
                r_cnt[k] <= i_clear ? '0 : o_next[k];
            end
        end
    end

endmodule

[tb/alignment_column_error_tally_core_tb.sv]
`timescale 1ns / 1ps

module alignment_column_error_tally_core_tb
    import acet_pkg::*;
();

    localparam int CountW    = 16;
    localparam int TallyBits = ((NumTally * CountW + 7) / 8) * 8;

    localparam logic [CharWidth-1:0] ChA     = "A";
    localparam logic [CharWidth-1:0] ChC     = "C";
    localparam logic [CharWidth-1:0] ChG     = "G";
    localparam logic [CharWidth-1:0] ChT     = "T";
    localparam logic [CharWidth-1:0] ChSpace = " ";

    typedef struct packed {
        logic [CharWidth-1:0] ref_ch;
        logic [CharWidth-1:0] read_ch;
        logic [CharWidth-1:0] match_ch;
        logic                 last;
    } t_column;

    typedef logic [TallyBits-1:0] t_tally_word;

    // Predicts the twelve counters of each alignment and checks result words.
    class t_tally_board;
        logic [IndexWidth-1:0] slop;
        logic                  region_on;
        logic [IndexWidth-1:0] region_lo;
        logic [IndexWidth-1:0] region_hi;

        logic [CharWidth-1:0]  prev_r, prev_q;
        logic [CharWidth-1:0]  held_r, held_q, held_m;
        logic                  held_ok, prev_ok;
        logic [IndexWidth-1:0] col_idx;
        logic [CountW-1:0]     tally [NumTally];

        t_tally_word expected_tallies [$];
        int failures;

        function new();
            slop      = '0;
            region_on = 1'b0;
            region_lo = '0;
            region_hi = '0;
            failures  = 0;
            restart();
        endfunction

        function void restart();
            prev_r  = '0;
            prev_q  = '0;
            held_r  = '0;
            held_q  = '0;
            held_m  = '0;
            held_ok = 1'b0;
            prev_ok = 1'b0;
            col_idx = '0;
            foreach (tally[k]) tally[k] = '0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CfgDataWidth-1:0] value);
            case (idx)
                CFG_SLOP:         slop = value;
                CFG_REGION_EN:    region_on = value[0];
                CFG_REGION_START: region_lo = value;
                CFG_REGION_STOP:  region_hi = value;
                default: ;
            endcase
        endfunction

        function void bump(int k);
            if (tally[k] != {CountW{1'b1}}) tally[k]++;
        endfunction

        function bit beside(logic [CharWidth-1:0] c, bit has_p, logic [CharWidth-1:0] p,
                            bit has_n, logic [CharWidth-1:0] n);
            return (has_p && p == c) || (has_n && n == c);
        endfunction

        function void classify(logic [CharWidth-1:0] r, logic [CharWidth-1:0] q,
                               logic [CharWidth-1:0] m, logic [IndexWidth-1:0] idx,
                               bit has_p, logic [CharWidth-1:0] pr, logic [CharWidth-1:0] pq,
                               bit has_n, logic [CharWidth-1:0] nr,
                               logic [CharWidth-1:0] nq);
            bit r_gap;
            bit q_gap;
            r_gap = (r == GapChar);
            q_gap = (q == GapChar);
            if (!r_gap) bump(TALLY_REFLEN);
            if (!q_gap) bump(TALLY_READLEN);
            if (m == MatchChar) begin
                bump(TALLY_MATCH);
                return;
            end
            bump(TALLY_DIFF);
            if (idx >= slop) begin
                bump(TALLY_ERR);
                if ((!r_gap && beside(r, has_p, pr, has_n, nr)) ||
                    (!q_gap && beside(q, has_p, pq, has_n, nq)))
                    bump(TALLY_HOMO);
                if (!r_gap && !q_gap) bump(TALLY_MM);
                else bump(TALLY_INDEL);
            end
            // region homopolymer looks at the strand opposite the gap
            if (region_on && idx >= region_lo && idx <= region_hi) begin
                if ((r_gap && beside(q, has_p, pq, has_n, nq)) ||
                    (q_gap && beside(r, has_p, pr, has_n, nr)))
                    bump(TALLY_RHOMO);
                if (!r_gap && !q_gap) bump(TALLY_RMM);
                else if (r_gap && !q_gap) bump(TALLY_RINS);
                else if (!r_gap && q_gap) bump(TALLY_RDEL);
            end
        endfunction

        function void take_column(t_column c);
            t_tally_word word;
            if (held_ok) begin
                classify(held_r, held_q, held_m, col_idx, prev_ok, prev_r, prev_q,
                         1'b1, c.ref_ch, c.read_ch);
                if (col_idx != IndexMax) col_idx++;
                prev_r  = held_r;
                prev_q  = held_q;
                prev_ok = 1'b1;
            end
            held_r  = c.ref_ch;
            held_q  = c.read_ch;
            held_m  = c.match_ch;
            held_ok = 1'b1;
            if (c.last) begin
                classify(held_r, held_q, held_m, col_idx, prev_ok, prev_r, prev_q,
                         1'b0, '0, '0);
                word = '0;
                for (int k = 0; k < NumTally; k++) word[k*CountW +: CountW] = tally[k];
                expected_tallies = {expected_tallies, word};
                restart();
            end
        endfunction

        function void check_tallies(t_tally_word got);
            t_tally_word want;
            if (expected_tallies.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = expected_tallies.pop_front();
            for (int k = 0; k < NumTally; k++) begin
                if (got[k*CountW +: CountW] !== want[k*CountW +: CountW]) begin
                    failures++;
                    if (failures <= 10)
                        $display("counter %0d mismatch: expected %0d, got %0d", k,
                                 want[k*CountW +: CountW], got[k*CountW +: CountW]);
                end
            end
        endfunction

        function int pending();
            return expected_tallies.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [23:0]              i_s_tdata = '0;  // ref_char, read_char, match_char
    logic                     i_s_tlast = 1'b0;  // last_column
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [TallyBits-1:0]     o_m_tdata;  // twelve counters, error_count lowest
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CfgIndexWidth-1:0] i_cfg_index = '0;
    logic [CfgDataWidth-1:0]  i_cfg_data = '0;

    int send_idle  = 0;
    int recv_stall = 0;

    t_tally_board board = new();

    alignment_column_error_tally_core #(.COUNT_WIDTH(CountW)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_m_tready = ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_tallies(o_m_tdata);
    end

    initial begin
        #400_000;
        $display("alignment_column_error_tally_core regression: fail");
        $finish;
    end

    function automatic t_column col(logic [CharWidth-1:0] r, logic [CharWidth-1:0] q,
                                    logic [CharWidth-1:0] m, logic last);
        t_column c;
        c.ref_ch   = r;
        c.read_ch  = q;
        c.match_ch = m;
        c.last     = last;
        return c;
    endfunction

    // mostly bases from a small alphabet so neighbours repeat, some gaps and noise
    function automatic logic [CharWidth-1:0] pick_char();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) return GapChar;
        if (sel < 23) return CharWidth'($urandom_range(255));
        case ($urandom_range(3))
            0: return ChA;
            1: return ChC;
            2: return ChG;
            default: return ChT;
        endcase
    endfunction

    function automatic t_column random_column(logic last, bit ref_base);
        t_column c;
        int sel;
        c.ref_ch  = ref_base ? (($urandom_range(1) == 1) ? ChA : ChC) : pick_char();
        c.read_ch = pick_char();
        c.last    = last;
        sel = $urandom_range(99);
        if (c.ref_ch == c.read_ch && c.ref_ch != GapChar)
            c.match_ch = (sel < 85) ? MatchChar : CharWidth'($urandom_range(255));
        else if (sel < 80)
            c.match_ch = ChSpace;
        else if (sel < 90)
            c.match_ch = MatchChar;
        else
            c.match_ch = CharWidth'($urandom_range(255));
        return c;
    endfunction

    task automatic send_column(t_column c);
        while ($urandom_range(99) < send_idle) @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = {c.match_ch, c.read_ch, c.ref_ch};
        i_s_tlast  = c.last;
        do @(posedge i_clk); while (!o_s_tready);
        board.take_column(c);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CfgDataWidth-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(logic [CfgDataWidth-1:0] slop, logic region_on,
                             logic [CfgDataWidth-1:0] lo, logic [CfgDataWidth-1:0] hi);
        write_reg(CFG_SLOP, slop);
        write_reg(CFG_REGION_EN, {15'd0, region_on});
        write_reg(CFG_REGION_START, lo);
        write_reg(CFG_REGION_STOP, hi);
    endtask

    // drain results, then wait so the block is idle
    task automatic settle();
        while (board.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_alignments(int columns, int long_pct);
        int sent;
        int len;
        sent = 0;
        while (sent < columns) begin
            len = ($urandom_range(99) < long_pct) ? $urandom_range(30, 90)
                                                  : $urandom_range(1, 30);
            for (int i = 0; i < len; i++) send_column(random_column(i == len - 1, 1'b0));
            sent += len;
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // single column alignment under reset settings
        send_column(col(ChA, ChC, ChSpace, 1'b1));
        settle();

        write_all(16'd0, 1'b1, 16'd0, 16'hFFFF);
        send_column(col(ChA, ChA, MatchChar, 1'b0));
        send_column(col(ChA, GapChar, ChSpace, 1'b0));
        send_column(col(GapChar, ChG, ChSpace, 1'b0));
        send_column(col(ChT, ChG, ChSpace, 1'b0));
        send_column(col(GapChar, GapChar, ChSpace, 1'b0));
        send_column(col(8'h00, 8'hFF, 8'hFF, 1'b0));
        send_column(col(8'hFF, 8'h00, 8'h00, 1'b0));
        send_column(col(ChC, ChC, MatchChar, 1'b1));
        send_column(col(ChG, GapChar, ChSpace, 1'b0));
        send_column(col(ChG, GapChar, ChSpace, 1'b1));
        send_column(col(ChT, ChT, 8'h78, 1'b0));
        send_column(col(GapChar, ChT, ChSpace, 1'b1));
        settle();

        send_idle  = 48;
        recv_stall = 0;
        write_all(CfgDataWidth'($urandom_range(10)), 1'b1, 16'd3, 16'd20);
        run_alignments(380, 20);
        settle();

        // empty region, nothing reaches the slop
        send_idle  = 0;
        recv_stall = 48;
        write_all(16'hFFFF, 1'b1, 16'd25, 16'd5);
        run_alignments(380, 20);
        settle();

        send_idle  = 10;
        recv_stall = 10;
        write_all(CfgDataWidth'($urandom_range(6)), 1'b0,
                  CfgDataWidth'($urandom_range(15)), CfgDataWidth'($urandom_range(10, 60)));
        run_alignments(190, 20);
        settle();
        write_all(CfgDataWidth'($urandom_range(6)), 1'b1,
                  CfgDataWidth'($urandom_range(15)), CfgDataWidth'($urandom_range(10, 60)));
        run_alignments(190, 30);
        settle();

        // short alignments back to back, region hugging the first columns
        send_idle  = 0;
        recv_stall = 0;
        write_all(16'd2, 1'b1, 16'd1, 16'd8);
        run_alignments(20, 0);
        settle();

        repeat (10) @(negedge i_clk);
        if (board.failures == 0)
            $display("alignment_column_error_tally_core regression: pass");
        else
            $display("alignment_column_error_tally_core regression: fail");
        $finish;
    end

endmodule

[sim.f]
design/acet_pkg.sv
design/acet_classify.sv
design/acet_tally.sv
design/alignment_column_error_tally_core.sv
tb/alignment_column_error_tally_core_tb.sv
